// File: hw/rtl/ifh_pkg.sv
// ----------------------------------------------------------------------------
// ifh_pkg
// Shared constants, codes and controller/datapath types of the interpolated
// feature histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package ifh_pkg;

  // Default sizes of the table set.
  localparam int MAX_LIMITS_DEFAULT      = 16;
  localparam int NUM_REF_SYMBOLS_DEFAULT = 6;

  // Read symbols 1..5 each own a row of tables.
  localparam int READ_SYMBOLS = 5;

  // Breakpoint count limits and its reset value.
  localparam int MIN_LIMITS       = 2;
  localparam int NUM_LIMITS_RESET = 16;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 40;
  localparam int WEIGHT_W = 17;

  // One unit of count in Q1.16.
  localparam logic [WEIGHT_W-1:0] ONE_UNIT = 17'h10000;

  // Operation codes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ACCUM  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd1;
  localparam logic [1:0] STATUS_BAD_SLOT   = 2'd2;

  // Configuration register byte addresses.
  localparam logic [1:0] ADDR_NUM_LIMITS = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_LOCATE,
    ST_FETCH_HI,
    ST_CAP_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_UP_RD,
    ST_UP_WR,
    ST_LO_RD,
    ST_LO_WR,
    ST_RESULT
  } ifh_state_e;

  // Address source of the breakpoint memory.
  typedef enum logic [1:0] {
    BP_SLOT,
    BP_SCAN,
    BP_LO,
    BP_HI
  } ifh_bp_sel_e;

  // Address source of the count memory.
  typedef enum logic [1:0] {
    CNT_CLR,
    CNT_SLOT,
    CNT_LO,
    CNT_HI
  } ifh_cnt_sel_e;

  typedef struct packed {
    logic         load;
    logic         clr_step;
    logic         bp_read;
    logic         bp_write;
    ifh_bp_sel_e  bp_sel;
    logic         scan_issue;
    logic         cap_lo;
    logic         cap_hi;
    logic         div_init;
    logic         div_step;
    logic         cnt_read;
    logic         cnt_write;
    ifh_cnt_sel_e cnt_sel;
    logic         emit;
  } ifh_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       skip;
    logic       clr_last;
    logic       scan_last;
    logic       below_zero;
    logic       below_all;
    logic       den_bad;
    logic       div_last;
  } ifh_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/interpolated_feature_histogram_top.sv
// ----------------------------------------------------------------------------
// interpolated_feature_histogram_top
// Soft histogram over piecewise-linear feature tables with a breakpoint
// count register on an APB-style port.
//
//   Channel   Direction  Handshake                     Payload
//   item      in         start, transfer when !busy    operation_i .. sample_value_i
//   result    out        result_valid_o, one cycle     count_value_o .. status_o
//   config    in/out     psel/penable/pwrite, pready=1 paddr, pwdata, prdata
//
// Write and read items pass from transfer through decode to the result
// state. An interpolating accumulate runs the one-per-cycle breakpoint scan
// over the memory read port, fetches both neighbors, then runs the 17-step
// serial divide and two count read-modify-writes. An accumulate below or
// above all breakpoints skips the neighbor fetch and the divide and does one
// read-modify-write, and one with non-ascending neighbors skips the divide.
// After reset the count memory is cleared one entry a cycle, all of its
// 5 * NUM_REFERENCE_SYMBOLS * MAX_LIMITS entries (480 by default), with busy
// high. The result strobe lasts one cycle and busy drops in that same cycle,
// so the next item can transfer while the result is on the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolated_feature_histogram_top #(
  parameter int MAX_LIMITS            = ifh_pkg::MAX_LIMITS_DEFAULT,
  parameter int NUM_REFERENCE_SYMBOLS = ifh_pkg::NUM_REF_SYMBOLS_DEFAULT
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire [1:0]                            operation_i,
  input  wire [2:0]                            reference_symbol_i,
  input  wire [2:0]                            read_symbol_i,
  input  wire [3:0]                            slot_i,
  input  wire signed [ifh_pkg::SAMPLE_W-1:0]   sample_value_i,
  output logic                                 result_valid_o,
  output logic [ifh_pkg::COUNT_W-1:0]          count_value_o,
  output logic [3:0]                           lower_bin_o,
  output logic [ifh_pkg::WEIGHT_W-1:0]         upper_weight_o,
  output logic [1:0]                           status_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [1:0]                            paddr,
  input  wire [31:0]                           pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int NW = $clog2(MAX_LIMITS + 1);
  localparam int N_RESET = (MAX_LIMITS < ifh_pkg::NUM_LIMITS_RESET) ?
                           MAX_LIMITS : ifh_pkg::NUM_LIMITS_RESET;

  // Breakpoint count register; written values are clamped to the legal range.
  logic [NW-1:0] n_q, n_d;
  logic [4:0]    wr_val;
  logic          cfg_wr;

  assign wr_val = pwdata[4:0];
  assign cfg_wr = psel && penable && pwrite && (paddr == ifh_pkg::ADDR_NUM_LIMITS);

  always_comb begin
    if (8'(wr_val) < 8'(ifh_pkg::MIN_LIMITS)) begin
      n_d = NW'(ifh_pkg::MIN_LIMITS);
    end else if (8'(wr_val) > 8'(MAX_LIMITS)) begin
      n_d = NW'(MAX_LIMITS);
    end else begin
      n_d = NW'(wr_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= NW'(N_RESET);
    end else if (cfg_wr) begin
      n_q <= n_d;
    end
  end

  assign prdata = 32'(n_q);
  assign pready = 1'b1;

  ifh_pkg::ifh_cmd_t  cmd;
  ifh_pkg::ifh_stat_t stat;

  ifh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ifh_dp #(
    .MAX_LIMITS            (MAX_LIMITS),
    .NUM_REFERENCE_SYMBOLS (NUM_REFERENCE_SYMBOLS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .n_i                (n_q),
    .operation_i        (operation_i),
    .reference_symbol_i (reference_symbol_i),
    .read_symbol_i      (read_symbol_i),
    .slot_i             (slot_i),
    .sample_value_i     (sample_value_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .result_valid_o     (result_valid_o),
    .count_value_o      (count_value_o),
    .lower_bin_o        (lower_bin_o),
    .upper_weight_o     (upper_weight_o),
    .status_o           (status_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ifh_ctrl.sv
// ----------------------------------------------------------------------------
// ifh_ctrl
// Sequencer of the histogram: clearing pass, decode, breakpoint scan,
// neighbor fetch, serial divide and the two count updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ifh_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire ifh_pkg::ifh_stat_t stat_i,
  output ifh_pkg::ifh_cmd_t   cmd_o,
  output logic                busy_o
);

  ifh_pkg::ifh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifh_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ifh_pkg::ST_CLEAR: begin
        cmd_o.clr_step  = 1'b1;
        cmd_o.cnt_write = 1'b1;
        cmd_o.cnt_sel   = ifh_pkg::CNT_CLR;
        if (stat_i.clr_last) begin
          state_d = ifh_pkg::ST_IDLE;
        end
      end
      ifh_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ifh_pkg::ST_DECODE;
        end
      end
      ifh_pkg::ST_DECODE: begin
        state_d = ifh_pkg::ST_RESULT;
        if (!stat_i.skip) begin
          case (stat_i.op)
            ifh_pkg::OP_WRITE: begin
              cmd_o.bp_write = 1'b1;
              cmd_o.bp_sel   = ifh_pkg::BP_SLOT;
            end
            ifh_pkg::OP_READ: begin
              cmd_o.cnt_read = 1'b1;
              cmd_o.cnt_sel  = ifh_pkg::CNT_SLOT;
            end
            ifh_pkg::OP_ACCUM: begin
              state_d = ifh_pkg::ST_SCAN;
            end
            default: begin
              state_d = ifh_pkg::ST_RESULT;
            end
          endcase
        end
      end
      ifh_pkg::ST_SCAN: begin
        cmd_o.bp_read    = 1'b1;
        cmd_o.bp_sel     = ifh_pkg::BP_SCAN;
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ifh_pkg::ST_SCAN_TAIL;
        end
      end
      ifh_pkg::ST_SCAN_TAIL: begin
        // The last breakpoint is compared during this cycle.
        state_d = ifh_pkg::ST_LOCATE;
      end
      ifh_pkg::ST_LOCATE: begin
        if (stat_i.below_zero || stat_i.below_all) begin
          state_d = ifh_pkg::ST_LO_RD;
        end else begin
          cmd_o.bp_read = 1'b1;
          cmd_o.bp_sel  = ifh_pkg::BP_LO;
          state_d       = ifh_pkg::ST_FETCH_HI;
        end
      end
      ifh_pkg::ST_FETCH_HI: begin
        cmd_o.bp_read = 1'b1;
        cmd_o.bp_sel  = ifh_pkg::BP_HI;
        cmd_o.cap_lo  = 1'b1;
        state_d       = ifh_pkg::ST_CAP_HI;
      end
      ifh_pkg::ST_CAP_HI: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = ifh_pkg::ST_DIV_INIT;
      end
      ifh_pkg::ST_DIV_INIT: begin
        if (stat_i.den_bad) begin
          state_d = ifh_pkg::ST_UP_RD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ifh_pkg::ST_DIV;
        end
      end
      ifh_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ifh_pkg::ST_UP_RD;
        end
      end
      ifh_pkg::ST_UP_RD: begin
        cmd_o.cnt_read = 1'b1;
        cmd_o.cnt_sel  = ifh_pkg::CNT_HI;
        state_d        = ifh_pkg::ST_UP_WR;
      end
      ifh_pkg::ST_UP_WR: begin
        cmd_o.cnt_write = 1'b1;
        cmd_o.cnt_sel   = ifh_pkg::CNT_HI;
        state_d         = ifh_pkg::ST_LO_RD;
      end
      ifh_pkg::ST_LO_RD: begin
        cmd_o.cnt_read = 1'b1;
        cmd_o.cnt_sel  = ifh_pkg::CNT_LO;
        state_d        = ifh_pkg::ST_LO_WR;
      end
      ifh_pkg::ST_LO_WR: begin
        cmd_o.cnt_write = 1'b1;
        cmd_o.cnt_sel   = ifh_pkg::CNT_LO;
        state_d         = ifh_pkg::ST_RESULT;
      end
      ifh_pkg::ST_RESULT: begin
        cmd_o.emit = 1'b1;
        state_d    = ifh_pkg::ST_IDLE;
      end
      default: begin
        state_d = ifh_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ifh_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/ifh_dp.sv
// ----------------------------------------------------------------------------
// ifh_dp
// Datapath of the histogram: item registers, breakpoint and count memories,
// scan counter, restoring divider and the saturating count update.
// ----------------------------------------------------------------------------
`default_nettype none

module ifh_dp #(
  parameter int MAX_LIMITS            = ifh_pkg::MAX_LIMITS_DEFAULT,
  parameter int NUM_REFERENCE_SYMBOLS = ifh_pkg::NUM_REF_SYMBOLS_DEFAULT,
  localparam int NW = $clog2(MAX_LIMITS + 1)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire [NW-1:0]                     n_i,
  input  wire [1:0]                        operation_i,
  input  wire [2:0]                        reference_symbol_i,
  input  wire [2:0]                        read_symbol_i,
  input  wire [3:0]                        slot_i,
  input  wire signed [ifh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  wire ifh_pkg::ifh_cmd_t           cmd_i,
  output ifh_pkg::ifh_stat_t               stat_o,
  output logic                             result_valid_o,
  output logic [ifh_pkg::COUNT_W-1:0]      count_value_o,
  output logic [3:0]                       lower_bin_o,
  output logic [ifh_pkg::WEIGHT_W-1:0]     upper_weight_o,
  output logic [1:0]                       status_o
);

  localparam int NUM_TABLES = ifh_pkg::READ_SYMBOLS * NUM_REFERENCE_SYMBOLS;
  localparam int DEPTH      = NUM_TABLES * MAX_LIMITS;
  localparam int AW         = $clog2(DEPTH);
  localparam int LW         = $clog2(MAX_LIMITS);
  localparam int CW         = ifh_pkg::COUNT_W;
  localparam int SW         = ifh_pkg::SAMPLE_W;
  localparam int WW         = ifh_pkg::WEIGHT_W;

  // Item registers.
  logic [1:0]           op_q;
  logic [2:0]           ref_q;
  logic [2:0]           rd_q;
  logic [3:0]           slot_q;
  logic signed [SW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      ref_q  <= reference_symbol_i;
      rd_q   <= read_symbol_i;
      slot_q <= slot_i;
      val_q  <= sample_value_i;
    end
  end

  logic       sym_bad;
  logic       slot_bad;
  logic       skip;
  logic [1:0] status_c;

  assign sym_bad = (rd_q < 3'd1) || (rd_q > 3'(ifh_pkg::READ_SYMBOLS)) ||
                   ({1'b0, ref_q} >= 4'(NUM_REFERENCE_SYMBOLS));
  assign slot_bad = (8'(slot_q) >= 8'(n_i));

  always_comb begin
    status_c = ifh_pkg::STATUS_OK;
    skip     = 1'b0;
    if (op_q == ifh_pkg::OP_IGNORE) begin
      skip = 1'b1;
    end else if (sym_bad) begin
      status_c = ifh_pkg::STATUS_BAD_SYMBOL;
      skip     = 1'b1;
    end else if (slot_bad && (op_q != ifh_pkg::OP_ACCUM)) begin
      status_c = ifh_pkg::STATUS_BAD_SLOT;
      skip     = 1'b1;
    end
  end

  // Table base address: ((read symbol - 1) * reference symbols + ref) * limits.
  logic [7:0]    tbl_c;
  logic [15:0]   base_wide;
  logic [AW-1:0] base_c;

  assign tbl_c     = (8'(rd_q) - 8'd1) * 8'(NUM_REFERENCE_SYMBOLS) + 8'(ref_q);
  assign base_wide = 16'(tbl_c) * 16'(MAX_LIMITS);
  assign base_c    = base_wide[AW-1:0];

  // Scan of the breakpoints.
  logic [LW-1:0] scan_idx_q;
  logic [NW-1:0] below_q;
  logic          cmp_pend_q;
  logic [SW-1:0] bp_rdata_q;
  logic [LW-1:0] lo_c;
  logic [LW-1:0] hi_c;

  assign lo_c = (below_q == '0) ? '0 : LW'(below_q - NW'(1));
  assign hi_c = lo_c + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      below_q    <= '0;
      cmp_pend_q <= 1'b0;
    end else begin
      cmp_pend_q <= cmd_i.scan_issue;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        below_q    <= '0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_idx_q <= scan_idx_q + LW'(1);
        end
        if (cmp_pend_q && ($signed(bp_rdata_q) <= val_q)) begin
          below_q <= below_q + NW'(1);
        end
      end
    end
  end

  // Breakpoint memory.
  logic [SW-1:0] bp_mem [DEPTH];
  logic [AW-1:0] bp_addr;

  always_comb begin
    case (cmd_i.bp_sel)
      ifh_pkg::BP_SLOT: bp_addr = base_c + AW'(LW'(slot_q));
      ifh_pkg::BP_SCAN: bp_addr = base_c + AW'(scan_idx_q);
      ifh_pkg::BP_LO:   bp_addr = base_c + AW'(lo_c);
      ifh_pkg::BP_HI:   bp_addr = base_c + AW'(hi_c);
      default:          bp_addr = base_c;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bp_write) begin
      bp_mem[bp_addr] <= val_q;
    end
    if (cmd_i.bp_read) begin
      bp_rdata_q <= bp_mem[bp_addr];
    end
  end

  // Neighbor breakpoints and divider.
  logic signed [SW-1:0] blo_q;
  logic signed [SW-1:0] bup_q;
  logic signed [SW:0]   den_c;
  logic signed [SW:0]   num_c;
  logic                 den_bad;
  logic [SW:0]          num_clamp;
  logic [SW-1:0]        den_q;
  logic [SW:0]          rem_q;
  logic [WW-1:0]        q_q;
  logic [4:0]           div_cnt_q;
  logic [SW+1:0]        trial;
  logic                 fits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lo) begin
      blo_q <= $signed(bp_rdata_q);
    end
    if (cmd_i.cap_hi) begin
      bup_q <= $signed(bp_rdata_q);
    end
  end

  assign den_c   = $signed({bup_q[SW-1], bup_q}) - $signed({blo_q[SW-1], blo_q});
  assign num_c   = $signed({val_q[SW-1], val_q}) - $signed({blo_q[SW-1], blo_q});
  assign den_bad = den_c[SW] || (den_c == '0);

  // Numerator is clamped into [0, difference] so the weight stays within one unit.
  assign num_clamp = num_c[SW] ? '0 : ((num_c > den_c) ? den_c : num_c);

  // The first step compares the numerator itself; later steps shift in zeros.
  assign trial = (div_cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign fits  = (trial >= {2'b00, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q <= den_c[SW-1:0];
      rem_q <= num_clamp;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? (SW+1)'(trial - {2'b00, den_q}) : (SW+1)'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q       <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.div_init) begin
      q_q       <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      q_q       <= {q_q[WW-2:0], fits};
      div_cnt_q <= div_cnt_q + 5'd1;
    end
  end

  // Count memory with saturating read-modify-write.
  logic [CW-1:0] cnt_mem [DEPTH];
  logic [CW-1:0] cnt_rdata_q;
  logic [AW-1:0] cnt_addr;
  logic [AW-1:0] clr_idx_q;
  logic [WW-1:0] amount;
  logic [CW:0]   sum;
  logic [CW-1:0] cnt_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_idx_q <= clr_idx_q + AW'(1);
    end
  end

  always_comb begin
    case (cmd_i.cnt_sel)
      ifh_pkg::CNT_CLR:  cnt_addr = clr_idx_q;
      ifh_pkg::CNT_SLOT: cnt_addr = base_c + AW'(LW'(slot_q));
      ifh_pkg::CNT_LO:   cnt_addr = base_c + AW'(lo_c);
      ifh_pkg::CNT_HI:   cnt_addr = base_c + AW'(hi_c);
      default:           cnt_addr = clr_idx_q;
    endcase
  end

  assign amount    = (cmd_i.cnt_sel == ifh_pkg::CNT_HI) ? q_q : (ifh_pkg::ONE_UNIT - q_q);
  assign sum       = {1'b0, cnt_rdata_q} + (CW+1)'(amount);
  assign cnt_wdata = (cmd_i.cnt_sel == ifh_pkg::CNT_CLR) ? '0 :
                     (sum[CW] ? '1 : sum[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_write) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (cmd_i.cnt_read) begin
      cnt_rdata_q <= cnt_mem[cnt_addr];
    end
  end

  // Status toward the controller.
  assign stat_o.op         = op_q;
  assign stat_o.skip       = skip;
  assign stat_o.clr_last   = (clr_idx_q == AW'(DEPTH - 1));
  assign stat_o.scan_last  = (NW'(scan_idx_q) == (n_i - NW'(1)));
  assign stat_o.below_zero = (below_q == '0);
  assign stat_o.below_all  = (below_q == n_i);
  assign stat_o.den_bad    = den_bad;
  assign stat_o.div_last   = (div_cnt_q == 5'd16);

  // Result registers.
  logic          valid_q;
  logic [CW-1:0] count_q;
  logic [3:0]    lower_q;
  logic [WW-1:0] weight_q;
  logic [1:0]    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      count_q  <= (!skip && (op_q == ifh_pkg::OP_READ)) ? cnt_rdata_q : '0;
      lower_q  <= (!skip && (op_q == ifh_pkg::OP_ACCUM)) ? 4'(lo_c) : 4'd0;
      weight_q <= (!skip && (op_q == ifh_pkg::OP_ACCUM)) ? q_q : '0;
      status_q <= status_c;
    end
  end

  assign result_valid_o = valid_q;
  assign count_value_o  = count_q;
  assign lower_bin_o    = lower_q;
  assign upper_weight_o = weight_q;
  assign status_o       = status_q;

  // Each item yields a single result strobe, and two strobes never come back to back.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held for more than one cycle");

  // A restoring step always leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < {1'b0, den_q}))
    else $error("divider remainder not below divisor");

  // The interpolated share never exceeds one unit.
  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (q_q <= ifh_pkg::ONE_UNIT))
    else $error("upper weight exceeds one unit");

  // The divider only runs on a positive breakpoint difference.
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> !den_bad)
    else $error("divider started with a non-positive divisor");

endmodule

`default_nettype wire

// File: tb/interpolated_feature_histogram_checker.sv
// ----------------------------------------------------------------------------
// interpolated_feature_histogram_checker
// Watches the item, result and configuration channels of the histogram block.
// It keeps its own copy of the breakpoint and count tables, works out the
// reply of every accepted item and compares each result strobe with the
// oldest reply still outstanding.
// ----------------------------------------------------------------------------
module interpolated_feature_histogram_checker
  import ifh_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire                       busy_i,
  input  wire [1:0]                 operation_i,
  input  wire [2:0]                 reference_symbol_i,
  input  wire [2:0]                 read_symbol_i,
  input  wire [3:0]                 slot_i,
  input  wire signed [SAMPLE_W-1:0] sample_value_i,
  input  wire                       result_valid_i,
  input  wire [COUNT_W-1:0]         count_value_i,
  input  wire [3:0]                 lower_bin_i,
  input  wire [WEIGHT_W-1:0]        upper_weight_i,
  input  wire [1:0]                 status_i,
  input  wire                       psel_i,
  input  wire                       penable_i,
  input  wire                       pwrite_i,
  input  wire                       pready_i,
  input  wire [1:0]                 paddr_i,
  input  wire [31:0]                pwdata_i,
  output int                        error_count_o,
  output int                        pending_count_o
);

  localparam int TableDepth = READ_SYMBOLS * NUM_REF_SYMBOLS_DEFAULT * MAX_LIMITS_DEFAULT;

  typedef struct packed {
    logic [COUNT_W-1:0]  count_value;
    logic [3:0]          lower_bin;
    logic [WEIGHT_W-1:0] upper_weight;
    logic [1:0]          status;
  } bin_reply_t;

  logic [SAMPLE_W-1:0] breakpoint_mem [TableDepth];
  logic [COUNT_W-1:0]  bin_count_mem [TableDepth];
  int unsigned         active_limits;
  bin_reply_t          queued_replies [$];

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      breakpoint_mem[i] = '0;
      bin_count_mem[i]  = '0;
    end
    active_limits   = NUM_LIMITS_RESET;
    error_count_o   = 0;
    pending_count_o = 0;
  end

  task automatic add_to_bin(input int unsigned idx, input logic [WEIGHT_W-1:0] amount);
    logic [COUNT_W:0] sum;
    sum = {1'b0, bin_count_mem[idx]} + amount;
    bin_count_mem[idx] = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  endtask

  task automatic compute_bin_reply(
    input  logic [1:0]                 op,
    input  logic [2:0]                 rd_sym,
    input  logic [2:0]                 ref_sym,
    input  logic [3:0]                 slot,
    input  logic signed [SAMPLE_W-1:0] value,
    output bin_reply_t                 reply
  );
    int unsigned base;
    int unsigned below;
    int unsigned lo;
    int          b_lo;
    int          b_hi;
    int          span;
    int          offset;
    longint      share;
    reply = '0;
    if (op == OP_IGNORE) begin
      reply = '0;
    end else if (rd_sym < 1 || rd_sym > READ_SYMBOLS ||
                 ref_sym >= NUM_REF_SYMBOLS_DEFAULT) begin
      reply.status = STATUS_BAD_SYMBOL;
    end else begin
      base = ((rd_sym - 1) * NUM_REF_SYMBOLS_DEFAULT + ref_sym) * MAX_LIMITS_DEFAULT;
      if (op != OP_ACCUM) begin
        if (slot >= active_limits) begin
          reply.status = STATUS_BAD_SLOT;
        end else if (op == OP_WRITE) begin
          breakpoint_mem[base + slot] = value;
        end else begin
          reply.count_value = bin_count_mem[base + slot];
        end
      end else begin
        below = 0;
        for (int i = 0; i < active_limits; i++) begin
          if ($signed(breakpoint_mem[base + i]) <= value) below++;
        end
        if (below == 0) begin
          add_to_bin(base, ONE_UNIT);
        end else if (below == active_limits) begin
          add_to_bin(base + active_limits - 1, ONE_UNIT);
          reply.lower_bin = 4'(active_limits - 1);
        end else begin
          lo     = below - 1;
          b_lo   = $signed(breakpoint_mem[base + lo]);
          b_hi   = $signed(breakpoint_mem[base + lo + 1]);
          span   = b_hi - b_lo;
          offset = value - b_lo;
          share  = 0;
          if (span > 0) begin
            // Out-of-order neighbors can leave the value outside the pair.
            if (offset < 0) offset = 0;
            if (offset > span) offset = span;
            share = (longint'(offset) * longint'(ONE_UNIT)) / span;
          end
          add_to_bin(base + lo + 1, WEIGHT_W'(share));
          add_to_bin(base + lo, ONE_UNIT - WEIGHT_W'(share));
          reply.lower_bin    = 4'(lo);
          reply.upper_weight = WEIGHT_W'(share);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch_channels
    bin_reply_t  reply;
    int unsigned lim;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (queued_replies.size() == 0) begin
          $display("%0t: result with nothing outstanding, status %0d", $time, status_i);
          error_count_o++;
        end else begin
          reply = queued_replies.pop_front();
          check_field("count_value", reply.count_value, count_value_i);
          check_field("lower_bin", reply.lower_bin, lower_bin_i);
          check_field("upper_weight", reply.upper_weight, upper_weight_i);
          check_field("status", reply.status, status_i);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_NUM_LIMITS) begin
        lim = pwdata_i[4:0];
        if (lim < MIN_LIMITS) lim = MIN_LIMITS;
        if (lim > MAX_LIMITS_DEFAULT) lim = MAX_LIMITS_DEFAULT;
        active_limits = lim;
      end
      if (start_i && !busy_i) begin
        compute_bin_reply(operation_i, read_symbol_i, reference_symbol_i, slot_i,
                          sample_value_i, reply);
        queued_replies.push_back(reply);
      end
      pending_count_o = queued_replies.size();
    end
  end

endmodule

// File: tb/interpolated_feature_histogram_top_tb.sv
// ----------------------------------------------------------------------------
// interpolated_feature_histogram_top_tb
// Drives the histogram block with a short directed pass over the corner
// cases, then with phases of random table sequences and noise, one breakpoint
// count setting per phase. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module interpolated_feature_histogram_top_tb;
  import ifh_pkg::*;

  localparam int NumTables     = READ_SYMBOLS * NUM_REF_SYMBOLS_DEFAULT;
  localparam int ItemsPerPhase = 100;
  localparam int NumPhases     = 7;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  wire                        busy;
  logic [1:0]                 operation_i;
  logic [2:0]                 reference_symbol_i;
  logic [2:0]                 read_symbol_i;
  logic [3:0]                 slot_i;
  logic signed [SAMPLE_W-1:0] sample_value_i;
  wire                        result_valid_o;
  wire [COUNT_W-1:0]          count_value_o;
  wire [3:0]                  lower_bin_o;
  wire [WEIGHT_W-1:0]         upper_weight_o;
  wire [1:0]                  status_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [1:0]                 paddr;
  logic [31:0]                pwdata;
  wire [31:0]                 prdata;
  wire                        pready;

  int error_count;
  int pending_count;

  int unsigned                   cur_limits;
  logic [MAX_LIMITS_DEFAULT-1:0] written_mask [NumTables];
  int                            table_points [MAX_LIMITS_DEFAULT];
  int                            items_sent;
  int                            burst_left;

  interpolated_feature_histogram_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_i),
    .reference_symbol_i (reference_symbol_i),
    .read_symbol_i      (read_symbol_i),
    .slot_i             (slot_i),
    .sample_value_i     (sample_value_i),
    .result_valid_o     (result_valid_o),
    .count_value_o      (count_value_o),
    .lower_bin_o        (lower_bin_o),
    .upper_weight_o     (upper_weight_o),
    .status_o           (status_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  interpolated_feature_histogram_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .operation_i        (operation_i),
    .reference_symbol_i (reference_symbol_i),
    .read_symbol_i      (read_symbol_i),
    .slot_i             (slot_i),
    .sample_value_i     (sample_value_i),
    .result_valid_i     (result_valid_o),
    .count_value_i      (count_value_o),
    .lower_bin_i        (lower_bin_o),
    .upper_weight_i     (upper_weight_o),
    .status_i           (status_o),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .pready_i           (pready),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .error_count_o      (error_count),
    .pending_count_o    (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit symbols_valid(input int rd_sym, input int ref_sym);
    return rd_sym >= 1 && rd_sym <= READ_SYMBOLS && ref_sym < NUM_REF_SYMBOLS_DEFAULT;
  endfunction

  function automatic int table_index(input int rd_sym, input int ref_sym);
    return (rd_sym - 1) * NUM_REF_SYMBOLS_DEFAULT + ref_sym;
  endfunction

  // An accumulate may only scan breakpoints that have been loaded.
  function automatic bit table_ready(input int t);
    int need;
    need = (1 << cur_limits) - 1;
    return (int'(written_mask[t]) & need) == need;
  endfunction

  function automatic int clamp_q88(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int rand_q88();
    logic [15:0] r;
    r = 16'($urandom);
    return int'($signed(r));
  endfunction

  task automatic send_item(input logic [1:0] op, input int rd_sym, input int ref_sym,
                           input int slot, input int value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
      if (gap > 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    operation_i        = op;
    read_symbol_i      = 3'(rd_sym);
    reference_symbol_i = 3'(ref_sym);
    slot_i             = 4'(slot);
    sample_value_i     = 16'(value);
    start              = 1'b1;
    do @(posedge clk_i); while (busy);
    burst_left--;
    if (op != OP_IGNORE) items_sent++;
    if (op == OP_WRITE && symbols_valid(rd_sym, ref_sym) && slot < cur_limits) begin
      written_mask[table_index(rd_sym, ref_sym)][slot] = 1'b1;
    end
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_limits(input int value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_NUM_LIMITS;
    pwdata  = {27'($urandom), 5'(value)};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cur_limits = (value < MIN_LIMITS) ? MIN_LIMITS
               : (value > MAX_LIMITS_DEFAULT) ? MAX_LIMITS_DEFAULT : value;
  endtask

  // Runs with two breakpoints per table.
  task automatic run_directed();
    send_item(OP_WRITE, 1, 0, 0, -256);
    send_item(OP_WRITE, 1, 0, 1, 512);
    send_item(OP_ACCUM, 1, 0, 15, -32768);
    send_item(OP_ACCUM, 1, 0, 0, -256);
    send_item(OP_ACCUM, 1, 0, 0, 100);
    send_item(OP_ACCUM, 1, 0, 0, 511);
    send_item(OP_ACCUM, 1, 0, 0, 512);
    send_item(OP_ACCUM, 1, 0, 0, 32767);
    send_item(OP_READ, 1, 0, 0, 0);
    send_item(OP_READ, 1, 0, 1, 0);
    send_item(OP_READ, 1, 0, 2, 0);
    send_item(OP_WRITE, 1, 0, 15, 32767);
    send_item(OP_WRITE, 0, 0, 0, 0);
    send_item(OP_ACCUM, 7, 7, 15, -1);
    send_item(OP_READ, 5, 6, 15, -1);
    send_item(OP_IGNORE, 7, 7, 15, -1);
    // Descending neighbors give no upper share.
    send_item(OP_WRITE, 5, 5, 0, 32767);
    send_item(OP_WRITE, 5, 5, 1, -32768);
    send_item(OP_ACCUM, 5, 5, 0, 0);
    send_item(OP_ACCUM, 5, 5, 0, 32767);
    send_item(OP_READ, 5, 5, 1, 0);
    send_item(OP_WRITE, 3, 2, 0, -32768);
    send_item(OP_WRITE, 3, 2, 1, 32767);
    send_item(OP_ACCUM, 3, 2, 0, 0);
    send_item(OP_READ, 3, 2, 1, 0);
  endtask

  // Loads a whole table, accumulates values mostly aimed at its breakpoints, then reads some slots.
  task automatic run_table_sequence();
    int rd_sym;
    int ref_sym;
    int style;
    int i;
    int j;
    int hold;
    int v;
    int lo_v;
    int hi_v;
    rd_sym  = $urandom_range(1, READ_SYMBOLS);
    ref_sym = $urandom_range(0, NUM_REF_SYMBOLS_DEFAULT - 1);
    style   = $urandom_range(0, 3);
    for (i = 0; i < cur_limits; i++) begin
      case (style)
        1: table_points[i] = (i == 0) ? rand_q88()
                           : clamp_q88(table_points[i-1] + int'($urandom_range(0, 8)));
        3: table_points[i] = 256 * (int'($urandom_range(0, 4)) - 2);
        default: table_points[i] = rand_q88();
      endcase
    end
    if (style != 2) begin
      for (i = 1; i < cur_limits; i++) begin
        hold = table_points[i];
        j = i - 1;
        while (j >= 0) begin
          if (table_points[j] <= hold) break;
          table_points[j+1] = table_points[j];
          j--;
        end
        table_points[j+1] = hold;
      end
    end
    for (i = 0; i < cur_limits; i++) begin
      send_item(OP_WRITE, rd_sym, ref_sym, i, table_points[i]);
    end
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(0, 5))
        0: v = rand_q88();
        1: v = table_points[$urandom_range(0, cur_limits - 1)];
        2: v = clamp_q88(table_points[$urandom_range(0, cur_limits - 1)]
                         + int'($urandom_range(0, 6)) - 3);
        3: begin
          j    = $urandom_range(0, cur_limits - 2);
          lo_v = table_points[j];
          hi_v = table_points[j+1];
          v    = (hi_v > lo_v) ? lo_v + int'($urandom_range(0, hi_v - lo_v - 1)) : lo_v;
        end
        4: v = clamp_q88(table_points[0] - int'($urandom_range(1, 64)));
        default: v = 32767 - int'($urandom_range(0, 3));
      endcase
      send_item(OP_ACCUM, rd_sym, ref_sym, $urandom_range(0, 15), v);
    end
    repeat ($urandom_range(1, 3)) begin
      send_item(OP_READ, rd_sym, ref_sym, $urandom_range(0, 15), rand_q88());
    end
  endtask

  task automatic run_noise_item();
    int rd_sym;
    int ref_sym;
    int k;
    int t;
    bit found;
    case ($urandom_range(0, 5))
      0: begin
        if ($urandom_range(0, 1) == 1) begin
          k       = $urandom_range(0, 2);
          rd_sym  = (k == 0) ? 0 : k + 5;
          ref_sym = $urandom_range(0, 7);
        end else begin
          rd_sym  = $urandom_range(1, READ_SYMBOLS);
          ref_sym = $urandom_range(NUM_REF_SYMBOLS_DEFAULT, 7);
        end
        send_item(2'($urandom_range(0, 2)), rd_sym, ref_sym, $urandom_range(0, 15),
                  rand_q88());
      end
      1: send_item(OP_IGNORE, $urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom_range(0, 15), rand_q88());
      2: send_item(($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ,
                   $urandom_range(1, READ_SYMBOLS),
                   $urandom_range(0, NUM_REF_SYMBOLS_DEFAULT - 1),
                   (cur_limits < MAX_LIMITS_DEFAULT) ? $urandom_range(cur_limits, 15)
                                                     : $urandom_range(0, 15),
                   rand_q88());
      3: send_item(OP_READ, $urandom_range(1, READ_SYMBOLS),
                   $urandom_range(0, NUM_REF_SYMBOLS_DEFAULT - 1),
                   $urandom_range(0, cur_limits - 1), rand_q88());
      4: send_item(OP_WRITE, $urandom_range(1, READ_SYMBOLS),
                   $urandom_range(0, NUM_REF_SYMBOLS_DEFAULT - 1),
                   $urandom_range(0, 15), rand_q88());
      default: begin
        found = 1'b0;
        k = $urandom_range(0, NumTables - 1);
        for (int n = 0; n < NumTables && !found; n++) begin
          t = (k + n) % NumTables;
          if (table_ready(t)) found = 1'b1;
        end
        if (found) begin
          send_item(OP_ACCUM, t / NUM_REF_SYMBOLS_DEFAULT + 1, t % NUM_REF_SYMBOLS_DEFAULT,
                    $urandom_range(0, 15), rand_q88());
        end else begin
          send_item(OP_READ, 1, 0, $urandom_range(0, 15), rand_q88());
        end
      end
    endcase
  endtask

  initial begin
    int phase_limits [NumPhases];
    int phase_end;
    int guard;
    rst_ni             = 1'b0;
    start              = 1'b0;
    operation_i        = OP_WRITE;
    reference_symbol_i = '0;
    read_symbol_i      = '0;
    slot_i             = '0;
    sample_value_i     = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cur_limits         = NUM_LIMITS_RESET;
    items_sent         = 0;
    burst_left         = 0;
    for (int t = 0; t < NumTables; t++) written_mask[t] = '0;
    phase_limits = '{16, 1, 9, 31, 2, 0, 16};
    phase_limits[5] = $urandom_range(0, 31);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The count memory is cleared after reset with busy high.
    repeat (2) @(negedge clk_i);
    while (busy) @(negedge clk_i);

    write_limits(MIN_LIMITS);
    run_directed();
    drain_replies();

    for (int p = 0; p < NumPhases; p++) begin
      write_limits(phase_limits[p]);
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 70) run_table_sequence();
        else run_noise_item();
        if ($urandom_range(0, 199) == 0) drain_replies();
      end
      drain_replies();
    end

    guard = 0;
    while (pending_count != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (60) @(negedge clk_i);
    if (pending_count != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_count);
    end
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ifh_pkg.sv
hw/rtl/ifh_ctrl.sv
hw/rtl/ifh_dp.sv
hw/rtl/interpolated_feature_histogram_top.sv
tb/interpolated_feature_histogram_checker.sv
tb/interpolated_feature_histogram_top_tb.sv
